// ----- rtl/tpf_pkg.sv -----
package tpf_pkg;

	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int MaxResults = 3;

	typedef enum logic [1:0] {
		ACT_KEEP  = 2'd0,
		ACT_SPACE = 2'd1,
		ACT_DROP  = 2'd2
	} action_t;

	typedef struct packed {
		logic [7:0] ch;
		action_t    act;
		logic       last;
	} result_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c inside {[8'h21:8'h7E]}) && !is_alpha(c) && !is_digit(c);
	endfunction

	function automatic action_t decide(input logic [7:0] c, input logic [7:0] n1,
			input logic [7:0] n2, input logic [7:0] p);
		action_t act;
		act = ACT_KEEP;
		if (is_digit(c)) begin
			act = ACT_DROP;
		end else if (c == CH_HYPHEN) begin
			if ((is_alpha(p) || p == CH_HYPHEN) && (is_alpha(n1) || n1 == CH_HYPHEN)) begin
				if (n1 == CH_HYPHEN && !is_alpha(n2)) begin
					act = ACT_DROP;
				end
			end else begin
				act = ACT_DROP;
			end
		end else if (c == CH_APOS) begin
			if (!(is_alpha(p) && is_alpha(n1))) begin
				act = ACT_DROP;
			end
		end else if (is_punct(c)) begin
			if (is_alpha(n1) || is_digit(n1) || is_punct(n1)) begin
				act = ACT_DROP;
			end else begin
				act = ACT_SPACE;
			end
		end
		return act;
	endfunction

	function automatic logic [7:0] next_prev(input logic [7:0] c, input action_t act,
			input logic [7:0] p);
		logic [7:0] r;
		case (act)
			ACT_KEEP:  r = c;
			ACT_SPACE: r = CH_SPACE;
			default:   r = p;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/tpf_ifs.sv -----
interface tpf_chr_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_end;

	modport source (output valid, output char_in, output line_end, input ready);
	modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface tpf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic [1:0] action;
	logic       line_last;

	modport source (output valid, output char_out, output action, output line_last,
		input ready);
	modport sink (input valid, input char_out, input action, input line_last,
		output ready);
endinterface

// ----- rtl/tpf_eval.sv -----
module tpf_eval import tpf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [7:0]                 ch,
	input  logic                       last,
	output logic [1:0]                 count,
	output result_t [MaxResults-1:0]   res
);

	logic [7:0] buf0_q;
	logic [7:0] buf1_q;
	logic [1:0] cnt_q;
	logic [7:0] prev_q;

	logic [7:0] seqx [MaxResults+2];
	action_t    act_l [MaxResults];
	logic [7:0] prev_l;
	logic [1:0] n_line;
	action_t    act_s;

	always_comb begin
		seqx[3] = '0;
		seqx[4] = '0;
		case (cnt_q)
			2'd0: begin
				seqx[0] = ch;
				seqx[1] = '0;
				seqx[2] = '0;
			end
			2'd1: begin
				seqx[0] = buf0_q;
				seqx[1] = ch;
				seqx[2] = '0;
			end
			default: begin
				seqx[0] = buf0_q;
				seqx[1] = buf1_q;
				seqx[2] = ch;
			end
		endcase
		n_line = cnt_q + 2'd1;

		prev_l = prev_q;
		for (int i = 0; i < MaxResults; i++) begin
			act_l[i] = decide(seqx[i], seqx[i+1], seqx[i+2], prev_l);
			prev_l   = next_prev(seqx[i], act_l[i], prev_l);
		end

		act_s = decide(buf0_q, buf1_q, ch, prev_q);
	end

	always_comb begin
		if (last) begin
			count = n_line;
			for (int i = 0; i < MaxResults; i++) begin
				res[i].ch   = seqx[i];
				res[i].act  = act_l[i];
				res[i].last = (2'(i) == n_line - 2'd1);
			end
		end else begin
			count = (cnt_q == 2'd2) ? 2'd1 : 2'd0;
			res[0].ch   = buf0_q;
			res[0].act  = act_s;
			res[0].last = 1'b0;
			for (int i = 1; i < MaxResults; i++) begin
				res[i].ch   = seqx[i];
				res[i].act  = act_l[i];
				res[i].last = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf0_q <= '0;
			buf1_q <= '0;
			cnt_q  <= '0;
			prev_q <= '0;
		end else if (fire) begin
			if (last) begin
				buf0_q <= '0;
				buf1_q <= '0;
				cnt_q  <= '0;
				prev_q <= '0;
			end else if (cnt_q == 2'd2) begin
				buf0_q <= buf1_q;
				buf1_q <= ch;
				prev_q <= next_prev(buf0_q, act_s, prev_q);
			end else begin
				if (cnt_q[0]) begin
					buf1_q <= ch;
				end else begin
					buf0_q <= ch;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

// ----- rtl/tpf_resq.sv -----
module tpf_resq import tpf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [1:0]               count,
	input  result_t [MaxResults-1:0] res,
	output logic                     can_load,
	tpf_res_if.source                results
);

	result_t [MaxResults-1:0] res_q;
	logic [1:0]               cnt_q;
	logic [1:0]               rd_q;
	logic                     pop;
	result_t                  head;

	always_comb begin
		case (rd_q)
			2'd0:    head = res_q[0];
			2'd1:    head = res_q[1];
			default: head = res_q[2];
		endcase
	end

	assign pop      = results.valid && results.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	assign results.valid     = (cnt_q != 2'd0);
	assign results.char_out  = head.ch;
	assign results.action    = head.act;
	assign results.line_last = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= count;
			rd_q  <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- rtl/text_punctuation_filter_core.sv -----
// Channel   Role   Beat payload
// chars     sink   char_in[7:0], line_end
// results   source char_out[7:0], action[1:0], line_last
//
// A character beat is registered, evaluated once the result queue can take it, and
// its results go into a three-entry result queue that drives results. One beat per
// cycle is sustained inside a line while results are taken; a line-end beat yields
// up to three results, one per cycle while results are taken, and holds off input
// until the queue is down to its last entry. Reset clears the lookahead, the queue
// and the stage valid. A results stall backs up into chars.ready in the same cycle.
module text_punctuation_filter_core import tpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tpf_chr_if.sink   chars,
	tpf_res_if.source results
);

	logic                     valid_s1;
	logic [7:0]               char_s1;
	logic                     last_s1;
	logic                     can_load;
	logic                     fire;
	logic [1:0]               count;
	result_t [MaxResults-1:0] res;

	assign fire        = valid_s1 && can_load;
	assign chars.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.line_end;
		end
	end

	tpf_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (char_s1),
		.last   (last_s1),
		.count  (count),
		.res    (res)
	);

	tpf_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.count    (count),
		.res      (res),
		.can_load (can_load),
		.results  (results)
	);

endmodule

// ----- rtl/tpf_checker.sv -----
module tpf_checker import tpf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] char_out,
	input logic [1:0] action,
	input logic       line_last
);

	// A stalled result beat must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(char_out) && $stable(action) && $stable(line_last))
	else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && (char_out >= 8'h30) && (char_out <= 8'h39) |-> action == ACT_DROP)
	else $error("digit not dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && ((char_out < 8'h21) || (char_out > 8'h7E) ||
			((char_out >= 8'h41) && (char_out <= 8'h5A)) ||
			((char_out >= 8'h61) && (char_out <= 8'h7A))) |-> action == ACT_KEEP)
	else $error("letter or non-printable byte not kept");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && (action == ACT_SPACE) |->
			(char_out != CH_HYPHEN) && (char_out != CH_APOS) &&
			(char_out >= 8'h21) && (char_out <= 8'h7E))
	else $error("space produced for a byte that is not plain punctuation");

endmodule

bind text_punctuation_filter_core tpf_checker u_tpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (results.valid),
	.ready     (results.ready),
	.char_out  (results.char_out),
	.action    (results.action),
	.line_last (results.line_last)
);

// ----- sim/text_punctuation_filter_core_test.sv -----
`timescale 1ns / 1ps

module text_punctuation_filter_core_test;
	import tpf_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandomChars = 230;

	typedef struct {
		logic [7:0] ch;
		logic       eol;
	} char_beat_t;

	logic clk;
	logic arst_n;

	tpf_chr_if chr_bus ();
	tpf_res_if res_bus ();

	text_punctuation_filter_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chr_bus),
		.results (res_bus)
	);

	char_beat_t char_queue [$];
	result_t    decisions_due [$];

	logic [7:0] window [2];
	int         held;
	logic [7:0] last_produced;

	int chr_total;
	int lines_sent;
	int chr_offered;
	int chr_taken;
	int chr_gap;
	bit chr_calm;
	int res_taken;
	int res_seen;
	int res_hold;
	bit res_calm;
	int err_count;
	int cycle_count;
	int act_seen [3];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic bit letter(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic bit numeral(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic bit mark(logic [7:0] c);
		return c >= 8'h21 && c <= 8'h7E && !letter(c) && !numeral(c);
	endfunction

	task automatic settle(input logic [7:0] c, input logic [7:0] n1, input logic [7:0] n2,
			input logic last);
		action_t act;
		result_t r;
		act = ACT_KEEP;
		if (numeral(c)) begin
			act = ACT_DROP;
		end else if (c == CH_HYPHEN) begin
			if (!((letter(last_produced) || last_produced == CH_HYPHEN) &&
					(letter(n1) || n1 == CH_HYPHEN))) begin
				act = ACT_DROP;
			end else if (n1 == CH_HYPHEN && !letter(n2)) begin
				act = ACT_DROP;
			end
		end else if (c == CH_APOS) begin
			if (!(letter(last_produced) && letter(n1))) begin
				act = ACT_DROP;
			end
		end else if (mark(c)) begin
			act = (letter(n1) || numeral(n1) || mark(n1)) ? ACT_DROP : ACT_SPACE;
		end
		if (act == ACT_KEEP) begin
			last_produced = c;
		end else if (act == ACT_SPACE) begin
			last_produced = CH_SPACE;
		end
		r.ch = c;
		r.act = act;
		r.last = last;
		decisions_due.push_back(r);
	endtask

	task automatic filter_char(input logic [7:0] ch, input logic eol);
		logic [7:0] seq [$];
		logic [7:0] n1;
		logic [7:0] n2;
		if (!eol) begin
			if (held == 2) begin
				settle(window[0], window[1], ch, 1'b0);
				window[0] = window[1];
				window[1] = ch;
			end else begin
				window[held] = ch;
				held++;
			end
		end else begin
			for (int i = 0; i < held; i++) seq.push_back(window[i]);
			seq.push_back(ch);
			for (int i = 0; i < seq.size(); i++) begin
				n1 = (i + 1 < seq.size()) ? seq[i + 1] : 8'h00;
				n2 = (i + 2 < seq.size()) ? seq[i + 2] : 8'h00;
				settle(seq[i], n1, n2, i == seq.size() - 1);
			end
			window[0] = 8'h00;
			window[1] = 8'h00;
			held = 0;
			last_produced = 8'h00;
		end
	endtask

	task automatic add_byte(input logic [7:0] ch, input logic eol);
		char_beat_t b;
		b.ch = ch;
		b.eol = eol;
		char_queue.push_back(b);
		chr_total++;
		if (eol) lines_sent++;
	endtask

	task automatic add_line(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			c = $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
				: 8'(8'h61 + $urandom_range(0, 25));
		end else if (r < 56) begin
			c = CH_HYPHEN;
		end else if (r < 63) begin
			c = CH_APOS;
		end else if (r < 73) begin
			do c = 8'($urandom_range(33, 126));
			while (!mark(c) || c == CH_HYPHEN || c == CH_APOS);
		end else if (r < 80) begin
			c = 8'(8'h30 + $urandom_range(0, 9));
		end else if (r < 88) begin
			c = CH_SPACE;
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (arst_n) begin
			if (chr_bus.valid && chr_bus.ready) begin
				filter_char(chr_bus.char_in, chr_bus.line_end);
				chr_taken++;
			end
			if (res_bus.valid && res_bus.ready) begin
				res_taken++;
				if (decisions_due.size() == 0) begin
					$error("unexpected decision: char_out=%h action=%0d line_last=%b",
						res_bus.char_out, res_bus.action, res_bus.line_last);
					err_count++;
				end else begin
					want = decisions_due.pop_front();
					if (res_bus.char_out !== want.ch) begin
						$error("char_out: expected %h, got %h", want.ch, res_bus.char_out);
						err_count++;
					end
					if (res_bus.action !== want.act) begin
						$error("action: expected %0d, got %0d", want.act, res_bus.action);
						err_count++;
					end
					if (res_bus.line_last !== want.last) begin
						$error("line_last: expected %b, got %b", want.last, res_bus.line_last);
						err_count++;
					end
					act_seen[want.act]++;
				end
			end
		end
	end

	always @(negedge clk) begin
		logic       nv;
		char_beat_t cur;
		if (arst_n) begin
			nv = chr_bus.valid;
			if (nv && chr_taken == chr_offered) nv = 1'b0;
			if (!nv) begin
				if (chr_gap > 0) begin
					chr_gap--;
				end else if (char_queue.size() > 0) begin
					cur = char_queue.pop_front();
					chr_bus.char_in <= cur.ch;
					chr_bus.line_end <= cur.eol;
					nv = 1'b1;
					chr_offered++;
					if ($urandom_range(0, 24) == 0) chr_calm = !chr_calm;
					chr_gap = chr_calm ? 0 : $urandom_range(0, 8);
				end
			end
			chr_bus.valid <= nv;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken != res_seen) begin
				res_seen = res_taken;
				if ($urandom_range(0, 24) == 0) res_calm = !res_calm;
				res_hold = res_calm ? 0 : $urandom_range(0, 8);
			end
			if (res_hold > 0) begin
				res_bus.ready <= 1'b0;
				res_hold--;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) @(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int len;
		int random_sent;
		arst_n = 1'b0;
		chr_bus.valid = 1'b0;
		chr_bus.char_in = 8'h00;
		chr_bus.line_end = 1'b0;
		res_bus.ready = 1'b0;
		window[0] = 8'h00;
		window[1] = 8'h00;
		held = 0;
		last_produced = 8'h00;
		chr_gap = $urandom_range(0, 8);
		res_hold = 0;

		add_line("a-b");
		add_line("x--y");
		add_line("z--");
		add_line("it's");
		add_line("'a");
		add_line("0!");
		add_line("a.b");
		add_line("9");
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);

		random_sent = 0;
		while (random_sent < RandomChars) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			for (int i = 0; i < len; i++) add_byte(pick_char(), i == len - 1);
			random_sent += len;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (chr_taken == chr_total);
		while (decisions_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d characters in %0d lines, %0d decisions checked", chr_total, lines_sent,
			res_taken);
		$display("decisions by action: keep %0d, space %0d, drop %0d", act_seen[ACT_KEEP],
			act_seen[ACT_SPACE], act_seen[ACT_DROP]);
		if (err_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
